[sv/bpa_pkg.sv]
// ----------------------------------------------------------------------------
// bpa_pkg - shared types and constants of the bitmap page allocator
// Bitmap geometry, derived widths, command and state codes, and the structs
// that pass between the sequencer and the word unit.
// ----------------------------------------------------------------------------
package bpa_pkg;

    // bitmap geometry (WORD_BITS a power of two)
    localparam int BITMAP_WORDS = 1024;
    localparam int WORD_BITS    = 32;

    localparam int WADDR_W = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
    localparam int BIT_W   = $clog2(WORD_BITS);
    localparam int PG_W    = WADDR_W + BIT_W;
    localparam int LEN_W   = BIT_W + 1;

    // fixed field widths
    localparam int PAGE_W  = 15;
    localparam int COUNT_W = 16;
    localparam int WIU_W   = 11;
    localparam int RUN_W   = COUNT_W + 1;

    // word index counter: must hold BITMAP_WORDS and any page's word index
    localparam int CUR_W = (WADDR_W + 1 > PAGE_W) ? WADDR_W + 1 : PAGE_W;

    // range search looks at CHUNK bits of a mixed word per cycle
    localparam int CHUNK   = 8;
    localparam int NCHUNK  = (WORD_BITS + CHUNK - 1) / CHUNK;
    localparam int CIDX_W  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

    // configuration port
    localparam int APB_DW    = 32;
    localparam int REG_IDX_W = 1;
    localparam int PADDR_W   = REG_IDX_W + 2;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [WADDR_W-1:0]   waddr_t;
    typedef logic [BIT_W-1:0]     bit_t;
    typedef logic [PG_W-1:0]      pg_t;
    typedef logic [LEN_W-1:0]     len_t;
    typedef logic [PAGE_W-1:0]    page_t;
    typedef logic [COUNT_W-1:0]   count_t;
    typedef logic [WIU_W-1:0]     wiu_t;
    typedef logic [RUN_W-1:0]     run_t;
    typedef logic [CUR_W-1:0]     cur_t;
    typedef logic [CIDX_W-1:0]    cidx_t;
    typedef logic [PADDR_W-1:0]   paddr_t;
    typedef logic [REG_IDX_W-1:0] reg_idx_t;
    typedef logic [APB_DW-1:0]    apb_data_t;

    localparam reg_idx_t REG_WORDS_IN_USE = reg_idx_t'(0);
    localparam wiu_t     WIU_RESET        = wiu_t'(1024);

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_NO_SPACE = 1'b1;

    typedef enum logic [1:0] {
        CMD_ALLOC_PAGE  = 2'd0,
        CMD_FREE_PAGE   = 2'd1,
        CMD_ALLOC_RANGE = 2'd2,
        CMD_FREE_RANGE  = 2'd3
    } cmd_e;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_EV,
        ST_SCAN_CH,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_RESULT
    } state_e;

    // word unit operands
    typedef struct packed {
        word_t  data;
        bit_t   off;
        count_t rem;
        cidx_t  chunk;
        run_t   run;
        pg_t    start;
        waddr_t widx;
        count_t need;
    } wu_in_t;

    // word unit results
    typedef struct packed {
        logic   any;
        logic   all_free;
        bit_t   low;
        word_t  pick;
        len_t   len;
        word_t  mask;
        run_t   full_run;
        pg_t    full_start;
        logic   full_found;
        run_t   chunk_run;
        pg_t    chunk_start;
        logic   chunk_found;
    } wu_out_t;

    // internal page index to the 15-bit result field
    function automatic page_t to_page(pg_t p);
        logic [PG_W+PAGE_W-1:0] t;
        t = {{PAGE_W{1'b0}}, p};
        return t[PAGE_W-1:0];
    endfunction

endpackage

[sv/bpa_if.sv]
// ----------------------------------------------------------------------------
// bpa_if - request and response channels of the bitmap page allocator
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface bpa_req_if;
    logic                 valid;
    logic                 ready;
    logic [1:0]           command;
    bpa_pkg::page_t       page;
    bpa_pkg::count_t      count;

    modport source (output valid, output command, output page, output count, input ready);
    modport sink   (input valid, input command, input page, input count, output ready);
endinterface

interface bpa_rsp_if;
    logic                 valid;
    logic                 ready;
    bpa_pkg::page_t       result_page;
    logic                 status;

    modport source (output valid, output result_page, output status, input ready);
    modport sink   (input valid, input result_page, input status, output ready);
endinterface

[sv/bpa_apb_regs.sv]
// ----------------------------------------------------------------------------
// bpa_apb_regs - configuration register block
// APB-style slave holding the search bound words_in_use.
// ----------------------------------------------------------------------------
module bpa_apb_regs (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  bpa_pkg::paddr_t      paddr,
    input  bpa_pkg::apb_data_t   pwdata,
    output bpa_pkg::apb_data_t   prdata,
    output logic                 pready,
    output bpa_pkg::wiu_t        words_in_use
);

    bpa_pkg::wiu_t      wiu_reg;
    bpa_pkg::wiu_t      wiu_next;
    bpa_pkg::reg_idx_t  reg_idx;
    logic               wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[bpa_pkg::PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        wiu_next = wiu_reg;
        if (wr_en && (reg_idx == bpa_pkg::REG_WORDS_IN_USE))
        begin
            wiu_next = pwdata[bpa_pkg::WIU_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wiu_reg <= bpa_pkg::WIU_RESET;
        end
        else
        begin
            wiu_reg <= wiu_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx == bpa_pkg::REG_WORDS_IN_USE)
        begin
            prdata = {{(bpa_pkg::APB_DW - bpa_pkg::WIU_W){1'b0}}, wiu_reg};
        end
    end

    assign words_in_use = wiu_reg;

endmodule

[sv/bpa_word_unit.sv]
// ----------------------------------------------------------------------------
// bpa_word_unit - shared bitmap word unit
// Lowest-free-bit pick, range mask build and run tracking over one word,
// reused by every command under the sequencer.
// ----------------------------------------------------------------------------
module bpa_word_unit (
    input  bpa_pkg::wu_in_t   wi,
    output bpa_pkg::wu_out_t  wo
);

    logic [bpa_pkg::CHUNK-1:0]  cb;
    logic [bpa_pkg::CHUNK-1:0]  cv;
    bpa_pkg::run_t              run;
    bpa_pkg::pg_t               start;
    logic                       found;
    bpa_pkg::len_t              room;
    bpa_pkg::len_t              end_pos;

    always_comb
    begin
        wo = '0;

        wo.any      = |wi.data;
        wo.all_free = &wi.data;

        // priority encode, lowest bit wins
        for (int i = bpa_pkg::WORD_BITS - 1; i >= 0; i--)
        begin
            if (wi.data[i])
            begin
                wo.low = bpa_pkg::bit_t'(i);
            end
        end
        for (int i = 0; i < bpa_pkg::WORD_BITS; i++)
        begin
            wo.pick[i] = wi.data[i] && (bpa_pkg::bit_t'(i) != wo.low);
        end

        // pages of the range that fall in this word
        room = bpa_pkg::len_t'(bpa_pkg::WORD_BITS) - bpa_pkg::len_t'(wi.off);
        if (wi.rem < bpa_pkg::count_t'(room))
        begin
            wo.len = bpa_pkg::len_t'(wi.rem);
        end
        else
        begin
            wo.len = room;
        end
        end_pos = bpa_pkg::len_t'(wi.off) + wo.len;
        for (int i = 0; i < bpa_pkg::WORD_BITS; i++)
        begin
            wo.mask[i] = (bpa_pkg::len_t'(i) >= bpa_pkg::len_t'(wi.off))
                      && (bpa_pkg::len_t'(i) < end_pos);
        end

        // whole word free
        wo.full_run   = wi.run + bpa_pkg::run_t'(bpa_pkg::WORD_BITS);
        wo.full_start = (wi.run == '0) ? {wi.widx, bpa_pkg::bit_t'(0)} : wi.start;
        wo.full_found = wo.full_run >= bpa_pkg::run_t'(wi.need);

        // mixed word: one chunk of bits, in order
        cb = '0;
        cv = '0;
        for (int c = 0; c < bpa_pkg::NCHUNK; c++)
        begin
            if (wi.chunk == bpa_pkg::cidx_t'(c))
            begin
                for (int j = 0; j < bpa_pkg::CHUNK; j++)
                begin
                    if (c * bpa_pkg::CHUNK + j < bpa_pkg::WORD_BITS)
                    begin
                        cb[j] = wi.data[c * bpa_pkg::CHUNK + j];
                        cv[j] = 1'b1;
                    end
                end
            end
        end

        run   = wi.run;
        start = wi.start;
        found = 1'b0;
        for (int j = 0; j < bpa_pkg::CHUNK; j++)
        begin
            if (cv[j] && !found)
            begin
                if (cb[j])
                begin
                    if (run == '0)
                    begin
                        start = {wi.widx,
                                 bpa_pkg::bit_t'(int'(wi.chunk) * bpa_pkg::CHUNK + j)};
                    end
                    run = run + bpa_pkg::run_t'(1);
                    if (run >= bpa_pkg::run_t'(wi.need))
                    begin
                        found = 1'b1;
                    end
                end
                else
                begin
                    run = '0;
                end
            end
        end
        wo.chunk_run   = run;
        wo.chunk_start = start;
        wo.chunk_found = found;
    end

endmodule

[sv/bpa_engine.sv]
// ----------------------------------------------------------------------------
// bpa_engine - allocation sequencer with bitmap memory
// Clears the bitmap after reset, then runs each command as a sequence of
// word reads, word-unit steps and word writes.
// ----------------------------------------------------------------------------
module bpa_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  bpa_pkg::wiu_t     words_in_use,
    bpa_req_if.sink           req,
    bpa_rsp_if.source         rsp
);

    bpa_pkg::word_t   mem [bpa_pkg::BITMAP_WORDS];
    bpa_pkg::word_t   rdata_reg;

    bpa_pkg::state_e  state_reg, state_next;
    bpa_pkg::waddr_t  clr_reg, clr_next;
    bpa_pkg::cmd_e    cmd_reg, cmd_next;
    bpa_pkg::count_t  count_reg, count_next;
    bpa_pkg::cur_t    cur_reg, cur_next;
    bpa_pkg::cur_t    limit_reg, limit_next;
    bpa_pkg::bit_t    off_reg, off_next;
    bpa_pkg::count_t  rem_reg, rem_next;
    bpa_pkg::cidx_t   chunk_reg, chunk_next;
    bpa_pkg::run_t    run_reg, run_next;
    bpa_pkg::pg_t     start_reg, start_next;
    bpa_pkg::page_t   res_page_reg, res_page_next;
    logic             res_status_reg, res_status_next;
    logic             out_valid_reg, out_valid_next;
    bpa_pkg::page_t   out_page_reg, out_page_next;
    logic             out_status_reg, out_status_next;

    logic             mem_we;
    bpa_pkg::waddr_t  mem_waddr;
    bpa_pkg::word_t   mem_wdata;
    logic             mem_re;
    bpa_pkg::waddr_t  mem_raddr;

    bpa_pkg::wu_in_t  wu_i;
    bpa_pkg::wu_out_t wu_o;

    logic             req_fire;
    bpa_pkg::cmd_e    req_cmd;
    bpa_pkg::cur_t    req_word;
    logic             req_word_in;
    bpa_pkg::cur_t    lim;
    bpa_pkg::cur_t    next_cur;
    logic             scan_end;
    bpa_pkg::count_t  rem_after;
    logic             mark_done;
    logic             last_chunk;
    logic             set_free;
    logic             out_load;

    assign req.ready   = (state_reg == bpa_pkg::ST_IDLE);
    assign req_fire    = req.valid && req.ready;
    assign req_cmd     = bpa_pkg::cmd_e'(req.command);
    assign req_word    = bpa_pkg::cur_t'(req.page >> bpa_pkg::BIT_W);
    assign req_word_in = req_word < bpa_pkg::cur_t'(bpa_pkg::BITMAP_WORDS);
    assign lim = (bpa_pkg::cur_t'(words_in_use) > bpa_pkg::cur_t'(bpa_pkg::BITMAP_WORDS))
               ? bpa_pkg::cur_t'(bpa_pkg::BITMAP_WORDS) : bpa_pkg::cur_t'(words_in_use);

    assign next_cur   = cur_reg + bpa_pkg::cur_t'(1);
    assign scan_end   = (next_cur == limit_reg);
    assign rem_after  = rem_reg - bpa_pkg::count_t'(wu_o.len);
    assign mark_done  = (rem_after == '0)
                     || (next_cur == bpa_pkg::cur_t'(bpa_pkg::BITMAP_WORDS));
    assign last_chunk = (chunk_reg == bpa_pkg::cidx_t'(bpa_pkg::NCHUNK - 1));
    assign set_free   = (cmd_reg == bpa_pkg::CMD_FREE_PAGE)
                     || (cmd_reg == bpa_pkg::CMD_FREE_RANGE);
    assign out_load   = (state_reg == bpa_pkg::ST_RESULT) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        wu_i       = '0;
        wu_i.data  = rdata_reg;
        wu_i.off   = off_reg;
        wu_i.rem   = rem_reg;
        wu_i.chunk = chunk_reg;
        wu_i.run   = run_reg;
        wu_i.start = start_reg;
        wu_i.widx  = cur_reg[bpa_pkg::WADDR_W-1:0];
        wu_i.need  = count_reg;
    end

    bpa_word_unit u_word_unit (
        .wi (wu_i),
        .wo (wu_o)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bpa_pkg::ST_CLEAR:
            begin
                if (clr_reg == bpa_pkg::waddr_t'(bpa_pkg::BITMAP_WORDS - 1))
                begin
                    state_next = bpa_pkg::ST_IDLE;
                end
            end
            bpa_pkg::ST_IDLE:
            begin
                if (req_fire)
                begin
                    unique case (req_cmd)
                        bpa_pkg::CMD_ALLOC_PAGE, bpa_pkg::CMD_ALLOC_RANGE:
                        begin
                            state_next = (lim == '0) ? bpa_pkg::ST_RESULT
                                                     : bpa_pkg::ST_SCAN_RD;
                        end
                        bpa_pkg::CMD_FREE_PAGE:
                        begin
                            state_next = req_word_in ? bpa_pkg::ST_MARK_RD
                                                     : bpa_pkg::ST_RESULT;
                        end
                        bpa_pkg::CMD_FREE_RANGE:
                        begin
                            state_next = (req_word_in && (req.count != '0))
                                       ? bpa_pkg::ST_MARK_RD : bpa_pkg::ST_RESULT;
                        end
                    endcase
                end
            end
            bpa_pkg::ST_SCAN_RD:
            begin
                state_next = bpa_pkg::ST_SCAN_EV;
            end
            bpa_pkg::ST_SCAN_EV:
            begin
                if (cmd_reg == bpa_pkg::CMD_ALLOC_PAGE)
                begin
                    if (wu_o.any || scan_end)
                        state_next = bpa_pkg::ST_RESULT;
                    else
                        state_next = bpa_pkg::ST_SCAN_RD;
                end
                else if (!wu_o.any)
                begin
                    state_next = scan_end ? bpa_pkg::ST_RESULT : bpa_pkg::ST_SCAN_RD;
                end
                else if (wu_o.all_free)
                begin
                    if (wu_o.full_found)
                        state_next = (count_reg == '0) ? bpa_pkg::ST_RESULT
                                                       : bpa_pkg::ST_MARK_RD;
                    else
                        state_next = scan_end ? bpa_pkg::ST_RESULT : bpa_pkg::ST_SCAN_RD;
                end
                else
                begin
                    state_next = bpa_pkg::ST_SCAN_CH;
                end
            end
            bpa_pkg::ST_SCAN_CH:
            begin
                if (wu_o.chunk_found)
                    state_next = (count_reg == '0) ? bpa_pkg::ST_RESULT
                                                   : bpa_pkg::ST_MARK_RD;
                else if (last_chunk)
                    state_next = scan_end ? bpa_pkg::ST_RESULT : bpa_pkg::ST_SCAN_RD;
            end
            bpa_pkg::ST_MARK_RD:
            begin
                state_next = bpa_pkg::ST_MARK_WR;
            end
            bpa_pkg::ST_MARK_WR:
            begin
                state_next = mark_done ? bpa_pkg::ST_RESULT : bpa_pkg::ST_MARK_RD;
            end
            bpa_pkg::ST_RESULT:
            begin
                if (out_load)
                    state_next = bpa_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        clr_next        = clr_reg;
        cmd_next        = cmd_reg;
        count_next      = count_reg;
        cur_next        = cur_reg;
        limit_next      = limit_reg;
        off_next        = off_reg;
        rem_next        = rem_reg;
        chunk_next      = chunk_reg;
        run_next        = run_reg;
        start_next      = start_reg;
        res_page_next   = res_page_reg;
        res_status_next = res_status_reg;
        mem_we          = 1'b0;
        mem_waddr       = cur_reg[bpa_pkg::WADDR_W-1:0];
        mem_wdata       = rdata_reg;
        mem_re          = 1'b0;
        mem_raddr       = cur_reg[bpa_pkg::WADDR_W-1:0];

        unique case (state_reg)
            bpa_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + bpa_pkg::waddr_t'(1);
            end
            bpa_pkg::ST_IDLE:
            begin
                if (req_fire)
                begin
                    cmd_next        = req_cmd;
                    count_next      = req.count;
                    limit_next      = lim;
                    off_next        = req.page[bpa_pkg::BIT_W-1:0];
                    run_next        = '0;
                    start_next      = '0;
                    chunk_next      = '0;
                    res_status_next = bpa_pkg::STATUS_OK;
                    unique case (req_cmd)
                        bpa_pkg::CMD_ALLOC_PAGE, bpa_pkg::CMD_ALLOC_RANGE:
                        begin
                            cur_next      = '0;
                            res_page_next = '0;
                            if (lim == '0)
                                res_status_next = bpa_pkg::STATUS_NO_SPACE;
                        end
                        bpa_pkg::CMD_FREE_PAGE:
                        begin
                            cur_next      = req_word;
                            rem_next      = bpa_pkg::count_t'(1);
                            res_page_next = req.page;
                        end
                        bpa_pkg::CMD_FREE_RANGE:
                        begin
                            cur_next      = req_word;
                            rem_next      = req.count;
                            res_page_next = req.page;
                        end
                    endcase
                end
            end
            bpa_pkg::ST_SCAN_RD, bpa_pkg::ST_MARK_RD:
            begin
                mem_re = 1'b1;
            end
            bpa_pkg::ST_SCAN_EV:
            begin
                if (cmd_reg == bpa_pkg::CMD_ALLOC_PAGE)
                begin
                    if (wu_o.any)
                    begin
                        mem_we        = 1'b1;
                        mem_wdata     = wu_o.pick;
                        res_page_next = bpa_pkg::to_page(
                                            {cur_reg[bpa_pkg::WADDR_W-1:0], wu_o.low});
                    end
                    else
                    begin
                        cur_next = next_cur;
                        if (scan_end)
                            res_status_next = bpa_pkg::STATUS_NO_SPACE;
                    end
                end
                else if (!wu_o.any)
                begin
                    run_next = '0;
                    cur_next = next_cur;
                    if (scan_end)
                        res_status_next = bpa_pkg::STATUS_NO_SPACE;
                end
                else if (wu_o.all_free)
                begin
                    run_next   = wu_o.full_run;
                    start_next = wu_o.full_start;
                    if (wu_o.full_found)
                    begin
                        res_page_next = bpa_pkg::to_page(wu_o.full_start);
                        cur_next      = bpa_pkg::cur_t'(
                                            wu_o.full_start[bpa_pkg::PG_W-1:bpa_pkg::BIT_W]);
                        off_next      = wu_o.full_start[bpa_pkg::BIT_W-1:0];
                        rem_next      = count_reg;
                    end
                    else
                    begin
                        cur_next = next_cur;
                        if (scan_end)
                            res_status_next = bpa_pkg::STATUS_NO_SPACE;
                    end
                end
                else
                begin
                    chunk_next = '0;
                end
            end
            bpa_pkg::ST_SCAN_CH:
            begin
                run_next   = wu_o.chunk_run;
                start_next = wu_o.chunk_start;
                if (wu_o.chunk_found)
                begin
                    res_page_next = bpa_pkg::to_page(wu_o.chunk_start);
                    cur_next      = bpa_pkg::cur_t'(
                                        wu_o.chunk_start[bpa_pkg::PG_W-1:bpa_pkg::BIT_W]);
                    off_next      = wu_o.chunk_start[bpa_pkg::BIT_W-1:0];
                    rem_next      = count_reg;
                end
                else if (last_chunk)
                begin
                    chunk_next = '0;
                    cur_next   = next_cur;
                    if (scan_end)
                        res_status_next = bpa_pkg::STATUS_NO_SPACE;
                end
                else
                begin
                    chunk_next = chunk_reg + bpa_pkg::cidx_t'(1);
                end
            end
            bpa_pkg::ST_MARK_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = set_free ? (rdata_reg | wu_o.mask) : (rdata_reg & ~wu_o.mask);
                rem_next  = rem_after;
                off_next  = '0;
                cur_next  = next_cur;
            end
            bpa_pkg::ST_RESULT:
            begin
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_page_next   = out_page_reg;
        out_status_next = out_status_reg;
        if (out_load)
        begin
            out_valid_next  = 1'b1;
            out_page_next   = res_page_reg;
            out_status_next = res_status_reg;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.result_page = out_page_reg;
    assign rsp.status      = out_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bpa_pkg::ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        count_reg      <= count_next;
        cur_reg        <= cur_next;
        limit_reg      <= limit_next;
        off_reg        <= off_next;
        rem_reg        <= rem_next;
        chunk_reg      <= chunk_next;
        run_reg        <= run_next;
        start_reg      <= start_next;
        res_page_reg   <= res_page_next;
        res_status_reg <= res_status_next;
        out_page_reg   <= out_page_next;
        out_status_reg <= out_status_next;
    end

    // bitmap store, read data registered
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

endmodule

[sv/bitmap_page_allocator.sv]
// ----------------------------------------------------------------------------
// bitmap_page_allocator - bitmap page frame allocator
// Single-page and first-fit range allocation and freeing over a bitmap of
// 1024 x 32-bit words (1 = page free), with a configurable search bound.
//
//   channel  dir  handshake         word
//   req      in   valid/ready       command, page, count
//   rsp      out  valid/ready       result_page, status
//   apb      in   psel/penable      words_in_use at offset 0x0
//
// Each bitmap word is read, then evaluated, through one memory port. Allocate
// page scans words up to the first free page. Allocate range scans whole
// words, walks each partly used word chunk by chunk, then marks the run word
// by word. Free commands read and write each word touched. After reset the
// bitmap is cleared one word a cycle, with req held not ready. A stalled rsp
// holds its word; req can take the next command, whose result then waits.
// ----------------------------------------------------------------------------
module bitmap_page_allocator (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  bpa_pkg::paddr_t      paddr,
    input  bpa_pkg::apb_data_t   pwdata,
    output bpa_pkg::apb_data_t   prdata,
    output logic                 pready,
    bpa_req_if.sink              req,
    bpa_rsp_if.source            rsp
);

    bpa_pkg::wiu_t words_in_use;

    bpa_apb_regs u_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .words_in_use (words_in_use)
    );

    bpa_engine u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .words_in_use (words_in_use),
        .req          (req),
        .rsp          (rsp)
    );

endmodule

[sv/bpa_checker.sv]
// ----------------------------------------------------------------------------
// bpa_checker - port-level checks on the bitmap page allocator
// Watches the request and response channels; bound to the top level.
// ----------------------------------------------------------------------------
module bpa_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    input  logic            req_ready,
    input  logic            rsp_valid,
    input  logic            rsp_ready,
    input  bpa_pkg::page_t  result_page,
    input  logic            status
);

    // one command at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while a command is in flight");

    // clearing pass follows reset
    a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !req_ready)
        else $error("request port open during bitmap clear");

    // a fresh result word comes from a busy block
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(!req_ready))
        else $error("result appeared without a command in flight");

    // no-space carries page zero
    a_fail_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == bpa_pkg::STATUS_NO_SPACE) |-> (result_page == '0))
        else $error("failed allocation with non-zero page");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(result_page) && $stable(status))
        else $error("stalled result word changed");

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .result_page (rsp.result_page),
    .status      (rsp.status)
);
